// ----- sv/btt_pkg.sv -----
// Shared widths, types and arithmetic helpers of the barycentric triangle test.
`default_nettype none
package btt_pkg;

   localparam int COORD_W          = 16;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int PROD_W           = 2 * DIFF_W;
   localparam int CROSS_W          = PROD_W + 1;
   localparam int NUM_W            = CROSS_W + 1;
   localparam int MAG_W            = NUM_W - 1;
   localparam int DEN_W            = CROSS_W - 1;
   localparam int REM_W            = MAG_W + 1;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int INT_STEPS        = 3;
   localparam int QUO_W            = WEIGHT_FRAC_BITS + INT_STEPS;
   localparam int DIV_STEPS        = QUO_W;
   localparam int WEIGHT_W         = QUO_W + 1;
   localparam int FRONT_STAGES     = 6;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } query_type;

   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      lane_type         lane_c;
      lane_type         lane_b;
      lane_type         lane_a;
      logic [DEN_W-1:0] den;
      logic             hit;
      logic             degen;
   } div_item_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_c;
      logic signed [WEIGHT_W-1:0] weight_b;
      logic signed [WEIGHT_W-1:0] weight_a;
      logic                       inside_res;
      logic                       degenerate;
   } result_type;

   // One restoring step: integer bits compare against a shifted divisor,
   // fraction bits shift the remainder instead.
   function automatic lane_type div_step(lane_type l, logic [DEN_W-1:0] d, int i);
      lane_type     o;
      logic [REM_W:0] r;
      logic [REM_W:0] t;
      logic           qb;
      o = l;
      if (i < INT_STEPS) begin
         r = {1'b0, l.rem};
         t = (REM_W+1)'(d) << (INT_STEPS - 1 - i);
      end else begin
         r = {l.rem, 1'b0};
         t = (REM_W+1)'(d);
      end
      qb = (r >= t);
      if (qb) begin
         r = r - t;
      end
      o.rem = r[REM_W-1:0];
      o.quo = {l.quo[QUO_W-2:0], qb};
      return o;
   endfunction

   // Apply sign with floor rounding, then saturate.
   function automatic logic signed [WEIGHT_W-1:0] finish(lane_type l);
      logic [WEIGHT_W-1:0] q;
      q = {1'b0, l.quo} + WEIGHT_W'(l.neg && (l.rem != '0));
      if (l.sat) begin
         return l.neg ? WEIGHT_MIN : WEIGHT_MAX;
      end
      return l.neg ? $signed(-q) : $signed(q);
   endfunction

endpackage
`default_nettype wire

// ----- sv/btt_front.sv -----
// Edge vectors, cross products, sign normalisation and divider set-up.
`default_nettype none
module btt_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire btt_pkg::query_type    in_query,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output btt_pkg::div_item_type      out_item
);

   logic [btt_pkg::FRONT_STAGES-1:0] v_ff;
   logic [btt_pkg::FRONT_STAGES:0]   rdy;

   logic signed [btt_pkg::DIFF_W-1:0]  e0x_ff, e0y_ff, e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [btt_pkg::PROD_W-1:0]  pd0_ff, pd1_ff, pu0_ff, pu1_ff, pv0_ff, pv1_ff;
   logic signed [btt_pkg::CROSS_W-1:0] den3_ff, nu3_ff, nv3_ff;
   logic signed [btt_pkg::CROSS_W-1:0] den4_ff, nu4_ff, nv4_ff;
   logic                               deg4_ff, deg5_ff;
   logic signed [btt_pkg::NUM_W-1:0]   nu5_ff, nv5_ff, nw5_ff;
   logic [btt_pkg::DEN_W-1:0]          den5_ff;
   btt_pkg::div_item_type              item_ff;

   function automatic logic signed [btt_pkg::DIFF_W-1:0] sub16(
      logic signed [btt_pkg::COORD_W-1:0] a, logic signed [btt_pkg::COORD_W-1:0] b);
      return btt_pkg::DIFF_W'(a) - btt_pkg::DIFF_W'(b);
   endfunction

   function automatic btt_pkg::lane_type lane_init(logic signed [btt_pkg::NUM_W-1:0] n,
                                                   logic [btt_pkg::DEN_W-1:0] d);
      btt_pkg::lane_type          l;
      logic [btt_pkg::NUM_W-1:0]  m;
      l.neg = n[btt_pkg::NUM_W-1];
      m     = l.neg ? -n : n;
      l.sat = ({2'b00, m[btt_pkg::MAG_W-1:0]} >= {d, 3'b000});
      l.rem = l.sat ? '0 : btt_pkg::REM_W'(m[btt_pkg::MAG_W-1:0]);
      l.quo = '0;
      return l;
   endfunction

   assign rdy[btt_pkg::FRONT_STAGES] = out_ready;
   for (genvar k = 0; k < btt_pkg::FRONT_STAGES; k++) begin : g_rdy
      assign rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[btt_pkg::FRONT_STAGES-1];
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int k = 1; k < btt_pkg::FRONT_STAGES; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         e0x_ff <= sub16(in_query.cx, in_query.ax);
         e0y_ff <= sub16(in_query.cy, in_query.ay);
         e1x_ff <= sub16(in_query.bx, in_query.ax);
         e1y_ff <= sub16(in_query.by, in_query.ay);
         e2x_ff <= sub16(in_query.px, in_query.ax);
         e2y_ff <= sub16(in_query.py, in_query.ay);
      end
      if (rdy[1]) begin
         pd0_ff <= e0x_ff * e1y_ff;
         pd1_ff <= e0y_ff * e1x_ff;
         pu0_ff <= e2x_ff * e1y_ff;
         pu1_ff <= e2y_ff * e1x_ff;
         pv0_ff <= e0x_ff * e2y_ff;
         pv1_ff <= e0y_ff * e2x_ff;
      end
      if (rdy[2]) begin
         den3_ff <= btt_pkg::CROSS_W'(pd0_ff) - btt_pkg::CROSS_W'(pd1_ff);
         nu3_ff  <= btt_pkg::CROSS_W'(pu0_ff) - btt_pkg::CROSS_W'(pu1_ff);
         nv3_ff  <= btt_pkg::CROSS_W'(pv0_ff) - btt_pkg::CROSS_W'(pv1_ff);
      end
      // flip signs so the denominator is positive
      if (rdy[3]) begin
         den4_ff <= den3_ff[btt_pkg::CROSS_W-1] ? -den3_ff : den3_ff;
         nu4_ff  <= den3_ff[btt_pkg::CROSS_W-1] ? -nu3_ff  : nu3_ff;
         nv4_ff  <= den3_ff[btt_pkg::CROSS_W-1] ? -nv3_ff  : nv3_ff;
         deg4_ff <= (den3_ff == '0);
      end
      if (rdy[4]) begin
         den5_ff <= den4_ff[btt_pkg::DEN_W-1:0];
         nu5_ff  <= btt_pkg::NUM_W'(nu4_ff);
         nv5_ff  <= btt_pkg::NUM_W'(nv4_ff);
         nw5_ff  <= btt_pkg::NUM_W'(den4_ff) - btt_pkg::NUM_W'(nu4_ff)
                    - btt_pkg::NUM_W'(nv4_ff);
         deg5_ff <= deg4_ff;
      end
      if (rdy[5]) begin
         item_ff.lane_c <= lane_init(nu5_ff, den5_ff);
         item_ff.lane_b <= lane_init(nv5_ff, den5_ff);
         item_ff.lane_a <= lane_init(nw5_ff, den5_ff);
         item_ff.den    <= den5_ff;
         item_ff.degen  <= deg5_ff;
         item_ff.hit    <= !deg5_ff && !nu5_ff[btt_pkg::NUM_W-1]
                           && !nv5_ff[btt_pkg::NUM_W-1] && !nw5_ff[btt_pkg::NUM_W-1];
      end
   end

endmodule
`default_nettype wire

// ----- sv/btt_div.sv -----
// Pipelined restoring divider for the three weights, one quotient bit per stage.
`default_nettype none
module btt_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire btt_pkg::div_item_type in_item,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output btt_pkg::result_type        out_result
);

   btt_pkg::div_item_type            st_ff [btt_pkg::DIV_STEPS];
   btt_pkg::div_item_type            src   [btt_pkg::DIV_STEPS+1];
   logic [btt_pkg::DIV_STEPS-1:0]    sv_ff;
   logic [btt_pkg::DIV_STEPS:0]      vsrc;
   logic [btt_pkg::DIV_STEPS:0]      rdy;
   btt_pkg::result_type              out_ff;
   logic                             out_v_ff;

   // advance all three lanes by one quotient bit
   function automatic btt_pkg::div_item_type step_item(btt_pkg::div_item_type it, int i);
      btt_pkg::div_item_type o;
      o        = it;
      o.lane_c = btt_pkg::div_step(it.lane_c, it.den, i);
      o.lane_b = btt_pkg::div_step(it.lane_b, it.den, i);
      o.lane_a = btt_pkg::div_step(it.lane_a, it.den, i);
      return o;
   endfunction

   assign src[0]  = in_item;
   assign vsrc[0] = in_valid;
   assign rdy[btt_pkg::DIV_STEPS] = !out_v_ff || out_ready;

   for (genvar i = 0; i < btt_pkg::DIV_STEPS; i++) begin : g_step
      assign src[i+1]  = st_ff[i];
      assign vsrc[i+1] = sv_ff[i];
      assign rdy[i]    = !sv_ff[i] || rdy[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            sv_ff[i] <= vsrc[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            st_ff[i] <= step_item(src[i], i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy[btt_pkg::DIV_STEPS]) begin
         out_v_ff <= vsrc[btt_pkg::DIV_STEPS];
      end
   end

   // degenerate triangles give zero weights
   always_ff @(posedge clock) begin
      if (rdy[btt_pkg::DIV_STEPS]) begin
         out_ff.weight_c   <= src[btt_pkg::DIV_STEPS].degen ? '0
                              : btt_pkg::finish(src[btt_pkg::DIV_STEPS].lane_c);
         out_ff.weight_b   <= src[btt_pkg::DIV_STEPS].degen ? '0
                              : btt_pkg::finish(src[btt_pkg::DIV_STEPS].lane_b);
         out_ff.weight_a   <= src[btt_pkg::DIV_STEPS].degen ? '0
                              : btt_pkg::finish(src[btt_pkg::DIV_STEPS].lane_a);
         out_ff.inside_res <= src[btt_pkg::DIV_STEPS].hit;
         out_ff.degenerate <= src[btt_pkg::DIV_STEPS].degen;
      end
   end

   assign in_ready   = rdy[0];
   assign out_valid  = out_v_ff;
   assign out_result = out_ff;

endmodule
`default_nettype wire

// ----- sv/barycentric_triangle_test.sv -----
// Top level of the barycentric point-in-triangle test.
`default_nettype none
// Channel  Direction  Data                                         Flags
// req_     in         point, vertices A, B, C (8 x 16-bit signed)  -
// rsp_     out        weight_c, weight_b, weight_a, inside_res     tuser: degenerate
//
// One request enters per clock unless rsp_ stalls. There are six front stages
// (edges, products, cross terms, sign flip, third numerator, divider set-up),
// nineteen divider stages (one quotient bit each) and the output register.
// Every stage holds its own valid bit and advances when it is empty or the
// next stage moves, so bubbles close up and a stall on rsp_ backs up stage by
// stage without loss. Reset (synchronous, active high) drops all valid bits.
module barycentric_triangle_test (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // point_x, point_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y
   input  wire logic [127:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // weight_c, weight_b, weight_a, inside_res, three zero bits
   output logic [63:0]        rsp_tdata,
   // degenerate
   output logic               rsp_tuser
);

   btt_pkg::query_type    query;
   btt_pkg::div_item_type mid_item;
   btt_pkg::result_type   result;
   logic                  mid_valid;
   logic                  mid_ready;

   // unpack the request, first field in the lowest bits
   assign query.px = req_tdata[15:0];
   assign query.py = req_tdata[31:16];
   assign query.ax = req_tdata[47:32];
   assign query.ay = req_tdata[63:48];
   assign query.bx = req_tdata[79:64];
   assign query.by = req_tdata[95:80];
   assign query.cx = req_tdata[111:96];
   assign query.cy = req_tdata[127:112];

   btt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_query  (query),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   btt_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_item    (mid_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'b000, result.inside_res, result.weight_a,
                       result.weight_b, result.weight_c};
   assign rsp_tuser = result.degenerate;

endmodule
`default_nettype wire
